FILE: rtl/core/lkvt_pkg.sv
// lkvt_pkg: item types, operation and status codes for the linear key-value table.
// Used by linear_key_value_table_core; depends on nothing.
package lkvt_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 64;

  // operation codes, the unused code acts as a lookup
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_DUP    = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [63:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  slot;
    logic [63:0] value_out;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic        is_full;
  } out_item_t;

endpackage

FILE: rtl/core/linear_key_value_table_core.sv
// linear_key_value_table_core: insertion-ordered key-value table with a linear search.
// Depends on lkvt_pkg for the item types and the operation and status codes.
//
// Usage:
//   in_valid/in_ready/in_data carry one operation item: lookup, insert or delete.
//   out_valid/out_ready/out_data carry exactly one result item per operation.
//   Keys and values sit in two synchronous memories (one read, one write a cycle).
//   An item is scanned from slot 0 upward, one entry per cycle, with the compare
//   in the cycle after the read. A delete hit then moves every later entry down one
//   slot, again one entry per cycle.
//   An insert of a new key into a table that is not full writes it into the first
//   free slot after the scan.
//   One item is in work at a time; in_ready is high only while the block waits
//   for an item. The result sits in an output register, so the next item is
//   taken while an earlier result waits for out_ready; a finished result waits
//   in its last state only when the output register is still occupied.
//   Reset empties the table at once (count zero); no clearing pass is needed.
module linear_key_value_table_core #(
  parameter int DEPTH      = lkvt_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = lkvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkvt_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lkvt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lkvt_pkg::out_item_t out_data
);
  import lkvt_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_INS, S_SHIFT, S_DONE} state_t;

  state_t state_r;

  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];
  logic [KEY_BITS-1:0]   key_rd_r;
  logic [VALUE_BITS-1:0] val_rd_r;

  logic [1:0]            kind_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] vin_r;
  logic [CNT_W-1:0]      fill_r;
  logic [CNT_W-1:0]      issue_r;
  logic                  pend_r;
  logic [IDX_W-1:0]      pend_idx_r;
  logic                  found_r;
  logic [IDX_W-1:0]      hit_idx_r;
  logic [VALUE_BITS-1:0] val_hit_r;
  logic [1:0]            status_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic                  busy;
  logic                  issue_go;
  logic                  hit_now;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_val;
  logic                  is_lookup;
  logic                  out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign busy      = (state_r == S_SCAN) || (state_r == S_SHIFT);
  assign issue_go  = busy && (issue_r < fill_r);
  assign hit_now   = (state_r == S_SCAN) && pend_r && (key_rd_r == key_r);
  assign is_lookup = (kind_r != KIND_INSERT) && (kind_r != KIND_DELETE);

  // the shift writes two slots behind the read, so read and write never meet
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_idx_r - IDX_W'(1);
    wr_key  = key_rd_r;
    wr_val  = val_rd_r;
    if (state_r == S_INS) begin
      wr_en   = 1'b1;
      wr_addr = fill_r[IDX_W-1:0];
      wr_key  = key_r;
      wr_val  = vin_r;
    end else if (state_r == S_SHIFT && pend_r) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    key_rd_r <= key_mem[issue_r[IDX_W-1:0]];
    val_rd_r <= val_mem[issue_r[IDX_W-1:0]];
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r    <= in_data.kind;
            key_r     <= in_data.key[KEY_BITS-1:0];
            vin_r     <= in_data.value_in[VALUE_BITS-1:0];
            issue_r   <= '0;
            pend_r    <= 1'b0;
            found_r   <= 1'b0;
            hit_idx_r <= '0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_r     <= issue_go;
          pend_idx_r <= issue_r[IDX_W-1:0];
          if (issue_go) begin
            issue_r <= issue_r + CNT_W'(1);
          end
          if (hit_now) begin
            found_r   <= 1'b1;
            hit_idx_r <= pend_idx_r;
            val_hit_r <= val_rd_r;
            status_r  <= (kind_r == KIND_INSERT) ? ST_DUP : ST_DONE;
            if (kind_r == KIND_DELETE) begin
              issue_r <= CNT_W'(pend_idx_r) + CNT_W'(1);
              pend_r  <= 1'b0;
              state_r <= S_SHIFT;
            end else begin
              state_r <= S_DONE;
            end
          end else if (!issue_go && !pend_r) begin
            if (kind_r == KIND_INSERT) begin
              if (fill_r == FULL_CNT) begin
                status_r <= ST_FULL;
                state_r  <= S_DONE;
              end else begin
                status_r <= ST_DONE;
                state_r  <= S_INS;
              end
            end else begin
              status_r <= ST_ABSENT;
              state_r  <= S_DONE;
            end
          end
        end
        S_INS: begin
          fill_r  <= fill_r + CNT_W'(1);
          state_r <= S_DONE;
        end
        S_SHIFT: begin
          pend_r     <= issue_go;
          pend_idx_r <= issue_r[IDX_W-1:0];
          if (issue_go) begin
            issue_r <= issue_r + CNT_W'(1);
          end else if (!pend_r) begin
            fill_r  <= fill_r - CNT_W'(1);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_r.found       <= found_r;
            out_r.slot        <= found_r ? 4'(hit_idx_r) : 4'd0;
            out_r.value_out   <= (found_r && is_lookup) ? 64'(val_hit_r) : 64'd0;
            out_r.status      <= status_r;
            out_r.entry_count <= 5'(fill_r);
            out_r.is_empty    <= (fill_r == '0);
            out_r.is_full     <= (fill_r == FULL_CNT);
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("entry count above table depth");

  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_SCAN && !in_ready)
    else $error("accepted item did not start a scan");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> CNT_W'(wr_addr) < fill_r || state_r == S_INS)
    else $error("memory write outside the filled slots");

  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.status == ST_DONE || out_data.status == ST_DUP)
    else $error("found result with a miss status");

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for linear_key_value_table_core, with directed table operations
// and random lookup/insert/delete traffic checked against a mirror of the table contents.
// Depends on lkvt_pkg and linear_key_value_table_core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvt_pkg::*;

  localparam int TBL_DEPTH    = DEPTH_DEF;
  localparam int POOL_SIZE    = 24;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTS   = 40;
  localparam int NO_MATCH     = -1;
  // unused operation code, the table treats it as a lookup
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic [63:0] key_mirror [TBL_DEPTH];
  logic [63:0] value_mirror [TBL_DEPTH];
  int          fill_level = 0;
  logic [63:0] key_pool [POOL_SIZE];
  out_item_t   expected_results [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  idle_mode_t  idle_mode = IDLE_NONE;

  linear_key_value_table_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_ready <= ($urandom_range(99) >= 86);
      IDLE_BOTH: out_ready <= ($urandom_range(99) >= 30);
      default:   out_ready <= 1'b1;
    endcase
  end

  // applies one operation to the mirrored table and returns the result it must produce
  function automatic out_item_t table_apply(in_item_t op);
    out_item_t res;
    int hit;
    hit = NO_MATCH;
    // scan downward so the lowest matching slot wins
    for (int i = fill_level - 1; i >= 0; i--) begin
      if (key_mirror[i] == op.key) hit = i;
    end
    res = '0;
    res.found = (hit != NO_MATCH);
    if (hit != NO_MATCH) res.slot = hit[3:0];
    case (op.kind)
      KIND_INSERT: begin
        if (hit != NO_MATCH) begin
          res.status = ST_DUP;
        end else if (fill_level >= TBL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          key_mirror[fill_level]   = op.key;
          value_mirror[fill_level] = op.value_in;
          fill_level++;
          res.status = ST_DONE;
        end
      end
      KIND_DELETE: begin
        if (hit != NO_MATCH) begin
          for (int j = hit; j < fill_level - 1; j++) begin
            key_mirror[j]   = key_mirror[j + 1];
            value_mirror[j] = value_mirror[j + 1];
          end
          fill_level--;
          res.status = ST_DONE;
        end else begin
          res.status = ST_ABSENT;
        end
      end
      default: begin
        if (hit != NO_MATCH) begin
          res.value_out = value_mirror[hit];
          res.status    = ST_DONE;
        end else begin
          res.status = ST_ABSENT;
        end
      end
    endcase
    res.entry_count = 5'(fill_level);
    res.is_empty    = (fill_level == 0);
    res.is_full     = (fill_level >= TBL_DEPTH);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no item pending", got.value_out, '0);
      return;
    end
    want = expected_results.pop_front();
    if (got.found !== want.found)
      report_mismatch("found", 64'(got.found), 64'(want.found));
    if (got.slot !== want.slot)
      report_mismatch("slot", 64'(got.slot), 64'(want.slot));
    if (got.value_out !== want.value_out) report_mismatch("value_out", got.value_out, want.value_out);
    if (got.status !== want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
    if (got.is_empty !== want.is_empty)
      report_mismatch("is_empty", 64'(got.is_empty), 64'(want.is_empty));
    if (got.is_full !== want.is_full)
      report_mismatch("is_full", 64'(got.is_full), 64'(want.is_full));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
  end

  task automatic send_op(in_item_t op);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 86 : (idle_mode == IDLE_BOTH) ? 30 : 0;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(table_apply(op));
  endtask

  function automatic in_item_t make_op(logic [1:0] kind, logic [63:0] key, logic [63:0] value);
    in_item_t op;
    op.kind     = kind;
    op.key      = key;
    op.value_in = value;
    return op;
  endfunction

  // keys still in the table stay reachable, the rest of the pool is fresh
  task automatic refill_key_pool(bit near_keys);
    logic [63:0] base;
    base = {$urandom, $urandom};
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < fill_level) key_pool[i] = key_mirror[i];
      else if (near_keys) key_pool[i] = base ^ (64'd1 << $urandom_range(63));
      else key_pool[i] = {$urandom, $urandom};
    end
  endtask

  function automatic in_item_t random_op(int ins_pct, int del_pct);
    in_item_t op;
    int pick;
    pick = $urandom_range(99);
    op.value_in = {$urandom, $urandom};
    case ($urandom_range(7))
      0: op.value_in = '0;
      1: op.value_in = '1;
      default: ;
    endcase
    if (pick < ins_pct) op.kind = KIND_INSERT;
    else if (pick < ins_pct + del_pct) op.kind = KIND_DELETE;
    else op.kind = ($urandom_range(7) == 0) ? KIND_SPARE : KIND_LOOKUP;
    // inserts use pool keys only so the table can always be drained again
    if (op.kind != KIND_INSERT && $urandom_range(99) < 12) op.key = {$urandom, $urandom};
    else op.key = key_pool[$urandom_range(POOL_SIZE - 1)];
    return op;
  endfunction

  task automatic run_random(int n, int ins_pct, int del_pct);
    repeat (n) send_op(random_op(ins_pct, del_pct));
  endtask

  task automatic test_directed_ops();
    logic [63:0] dkey [TBL_DEPTH];
    logic [63:0] dval;
    for (int i = 0; i < TBL_DEPTH; i++) dkey[i] = 64'(i) * 64'h9e37_79b9_7f4a_7c15;
    dkey[TBL_DEPTH - 1] = '1;
    idle_mode = IDLE_NONE;
    send_op(make_op(KIND_LOOKUP, dkey[0], '1));
    send_op(make_op(KIND_DELETE, '1, '0));
    for (int i = 0; i < TBL_DEPTH; i++) begin
      dval = (i == 0) ? '1 : (i == TBL_DEPTH - 1) ? '0 : ~dkey[i];
      send_op(make_op(KIND_INSERT, dkey[i], dval));
    end
    send_op(make_op(KIND_INSERT, 64'h5555_5555_5555_5555, 64'h1234));
    // duplicate wins over full
    send_op(make_op(KIND_INSERT, dkey[0], 64'h77));
    send_op(make_op(KIND_SPARE, dkey[TBL_DEPTH - 1], '1));
    // deleting slot zero shifts every later entry down
    send_op(make_op(KIND_DELETE, dkey[0], '1));
    send_op(make_op(KIND_LOOKUP, dkey[TBL_DEPTH - 1], '0));
    send_op(make_op(KIND_DELETE, dkey[7], '0));
    send_op(make_op(KIND_LOOKUP, dkey[0], '0));
  endtask

  task automatic test_mixed_traffic();
    refill_key_pool(1'b0);
    for (int m = 0; m < 4; m++) begin
      idle_mode = idle_mode_t'(m);
      run_random(180, 40, 25);
    end
  endtask

  task automatic test_fill_and_drain();
    refill_key_pool(1'b0);
    for (int m = 0; m < 4; m++) begin
      idle_mode = idle_mode_t'(m);
      run_random(60, 75, 10);
      run_random(60, 10, 70);
    end
  endtask

  // keys that each differ from one shared base in a single bit check that the whole key word is compared
  task automatic test_near_keys();
    refill_key_pool(1'b1);
    idle_mode = IDLE_BOTH;
    run_random(150, 45, 25);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_mixed_traffic();
    test_fill_and_drain();
    test_near_keys();

    @(negedge clk);
    in_valid <= 1'b0;
    idle_mode = IDLE_NONE;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
